// ===== rtl/core/load_cell_adc_reader_assert.svh =====
// Assertion macros for the load cell ADC reader
`ifndef LOAD_CELL_ADC_READER_ASSERT_SVH
`define LOAD_CELL_ADC_READER_ASSERT_SVH
`ifndef SYNTHESIS
`define LCAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LCAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LCAR_ASSERT(lbl, prop, msg)
`define LCAR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/lcar_pkg.sv =====
// Shared constants and types of the load cell ADC reader
package lcar_pkg;

  localparam int DATA_BITS  = 24;
  localparam int ACC_W      = 32;
  localparam int CNT_W      = 8;
  localparam int BIT_IDX_W  = 5;
  localparam int DIVD_W     = 41;
  localparam int DIVS_W     = 24;
  localparam int FRAC_SHIFT = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0]     SAMPLE_COUNT_RST = 8'd10;
  localparam logic [DATA_BITS-1:0] TARE_RST         = '0;
  localparam logic [DIVS_W-1:0]    SCALE_RST        = 24'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_TARE_VALUE   = 2'd1,
    CFG_SCALE_Q8     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic clr_acc;
    logic clr_word;
    logic shift_en;
    logic shift_bit;
    logic acc_add;
    logic avg_start;
    logic avg_cap;
    logic net_start;
    logic net_cap;
    logic load_res;
  } dp_cmd_t;

  typedef struct packed {
    logic             div_done;
    logic [CNT_W-1:0] count;
  } dp_sts_t;

endpackage

// ===== rtl/core/lcar_div.sv =====
// Bit-serial restoring divider, one quotient bit per clock
module lcar_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lcar_pkg::DIVD_W-1:0]     dividend_i,
  input  logic [lcar_pkg::DIVS_W-1:0]     divisor_i,
  output logic                            done_o,
  output logic [lcar_pkg::DIVD_W-1:0]     quot_o
);

  localparam int STEP_W = $clog2(lcar_pkg::DIVD_W);

  logic [lcar_pkg::DIVD_W-1:0] quot_q, quot_d;
  logic [lcar_pkg::DIVS_W-1:0] rem_q, rem_d;
  logic [lcar_pkg::DIVS_W-1:0] dvs_q;
  logic [STEP_W-1:0]           step_q;
  logic                        busy_q;
  logic                        done_q;
  logic [lcar_pkg::DIVS_W:0]   trial;
  logic                        qbit;

  always_comb begin
    trial = {rem_q, quot_q[lcar_pkg::DIVD_W-1]};
    qbit  = (trial >= {1'b0, dvs_q});
    if (qbit) begin
      rem_d = lcar_pkg::DIVS_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[lcar_pkg::DIVS_W-1:0];
    end
    quot_d = {quot_q[lcar_pkg::DIVD_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(lcar_pkg::DIVD_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/lcar_dp.sv =====
// Datapath: config registers, shift word, accumulator, divider and result registers
module lcar_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lcar_pkg::DIVS_W-1:0]         cfg_data_i,
  input  lcar_pkg::dp_cmd_t                   cmd_i,
  output lcar_pkg::dp_sts_t                   sts_o,
  output logic [lcar_pkg::DATA_BITS-1:0]      average_raw_o,
  output logic signed [lcar_pkg::DIVD_W-1:0]  net_weight_q8_o
);

  logic [lcar_pkg::CNT_W-1:0]     sample_count_q;
  logic [lcar_pkg::DATA_BITS-1:0] tare_q;
  logic [lcar_pkg::DIVS_W-1:0]    scale_q;
  logic [lcar_pkg::DATA_BITS-1:0] word_q;
  logic [lcar_pkg::ACC_W-1:0]     acc_q;
  logic [lcar_pkg::DATA_BITS-1:0] avg_q;
  logic                           neg_q;
  logic [lcar_pkg::DIVD_W-1:0]    net_q;
  logic [lcar_pkg::DATA_BITS-1:0] avg_res_q;
  logic [lcar_pkg::DIVD_W-1:0]    net_res_q;

  logic [lcar_pkg::CNT_W-1:0]     count;
  logic [lcar_pkg::DIVS_W-1:0]    scale;
  logic [lcar_pkg::DATA_BITS:0]   diff;
  logic [lcar_pkg::DATA_BITS:0]   diff_abs;
  logic [lcar_pkg::DATA_BITS-1:0] offs_word;
  logic                           div_start;
  logic [lcar_pkg::DIVD_W-1:0]    div_dividend;
  logic [lcar_pkg::DIVS_W-1:0]    div_divisor;
  logic                           div_done;
  logic [lcar_pkg::DIVD_W-1:0]    div_quot;

  assign count     = (sample_count_q == '0) ? lcar_pkg::CNT_W'(1) : sample_count_q;
  assign scale     = (scale_q == '0) ? lcar_pkg::DIVS_W'(1) : scale_q;
  assign diff      = {1'b0, avg_q} - {1'b0, tare_q};
  assign diff_abs  = diff[lcar_pkg::DATA_BITS] ? -diff : diff;
  assign offs_word = word_q ^ {1'b1, {(lcar_pkg::DATA_BITS-1){1'b0}}};

  assign div_start = cmd_i.avg_start | cmd_i.net_start;

  always_comb begin
    if (cmd_i.avg_start) begin
      div_dividend = lcar_pkg::DIVD_W'(acc_q);
      div_divisor  = lcar_pkg::DIVS_W'(count);
    end else begin
      div_dividend = {1'b0, diff_abs[lcar_pkg::DATA_BITS-1:0],
                      {lcar_pkg::FRAC_SHIFT{1'b0}}};
      div_divisor  = scale;
    end
  end

  lcar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= lcar_pkg::SAMPLE_COUNT_RST;
      tare_q         <= lcar_pkg::TARE_RST;
      scale_q        <= lcar_pkg::SCALE_RST;
      avg_res_q      <= '0;
      net_res_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (lcar_pkg::cfg_idx_e'(cfg_idx_i))
          lcar_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[lcar_pkg::CNT_W-1:0];
          lcar_pkg::CFG_TARE_VALUE:   tare_q         <= cfg_data_i;
          lcar_pkg::CFG_SCALE_Q8:     scale_q        <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load_res) begin
        avg_res_q <= avg_q;
        net_res_q <= net_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_word) begin
      word_q <= '0;
    end else if (cmd_i.shift_en) begin
      word_q <= {word_q[lcar_pkg::DATA_BITS-2:0], cmd_i.shift_bit};
    end
    if (cmd_i.clr_acc) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + lcar_pkg::ACC_W'(offs_word);
    end
    if (cmd_i.avg_cap) begin
      avg_q <= div_quot[lcar_pkg::DATA_BITS-1:0];
    end
    if (cmd_i.net_start) begin
      neg_q <= diff[lcar_pkg::DATA_BITS];
    end
    if (cmd_i.net_cap) begin
      net_q <= neg_q ? -div_quot : div_quot;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.count    = count;

  assign average_raw_o   = avg_res_q;
  assign net_weight_q8_o = net_res_q;

endmodule

// ===== rtl/core/lcar_ctrl.sv =====
// Controller: converter bit-bang sequencer, divide sequencing and beat handshake
module lcar_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               start_req_i,
  input  logic               dout_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               sck_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output lcar_pkg::dp_cmd_t  cmd_o,
  input  lcar_pkg::dp_sts_t  sts_i
);

  `include "load_cell_adc_reader_assert.svh"

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_RISE, PH_FALL, PH_GAP, PH_XHIGH, PH_XLOW
  } phase_e;

  typedef enum logic [2:0] {
    C_TICK, C_AVG_GO, C_AVG_WAIT, C_NET_GO, C_NET_WAIT, C_LOAD
  } ctrl_e;

  ctrl_e                          state_q;
  phase_e                         phase_q, phase_d;
  logic [lcar_pkg::BIT_IDX_W-1:0] bit_q, bit_d;
  logic [lcar_pkg::CNT_W-1:0]     smp_q, smp_d;
  logic                           clk_lvl_q, clk_lvl_d;
  logic                           out_valid_q, sck_q, busy_q, done_q;

  lcar_pkg::dp_cmd_t tick_cmd;
  logic              final_tick;
  logic              out_free;
  logic              accept;
  logic              beat_set;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = (state_q == C_TICK) && in_valid_i && out_free;
  assign beat_set = (state_q == C_TICK) ? (accept && !final_tick)
                                        : ((state_q == C_LOAD) && out_free);

  always_comb begin
    phase_d    = phase_q;
    bit_d      = bit_q;
    smp_d      = smp_q;
    clk_lvl_d  = clk_lvl_q;
    final_tick = 1'b0;
    tick_cmd   = '0;
    tick_cmd.shift_bit = dout_i;
    case (phase_q)
      PH_IDLE: begin
        clk_lvl_d = 1'b0;
        if (start_req_i) begin
          tick_cmd.clr_acc = 1'b1;
          smp_d   = '0;
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        clk_lvl_d = 1'b0;
        if (!dout_i) begin
          tick_cmd.clr_word = 1'b1;
          bit_d   = '0;
          phase_d = PH_RISE;
        end
      end
      PH_RISE: begin
        clk_lvl_d = 1'b1;
        phase_d   = PH_FALL;
      end
      PH_FALL: begin
        clk_lvl_d = 1'b0;
        tick_cmd.shift_en = 1'b1;
        bit_d   = bit_q + 1'b1;
        phase_d = PH_GAP;
      end
      PH_GAP: begin
        if (bit_q < lcar_pkg::BIT_IDX_W'(lcar_pkg::DATA_BITS)) begin
          phase_d = PH_RISE;
        end else begin
          clk_lvl_d = 1'b1;
          phase_d   = PH_XHIGH;
        end
      end
      PH_XHIGH: begin
        clk_lvl_d = 1'b0;
        phase_d   = PH_XLOW;
      end
      PH_XLOW: begin
        clk_lvl_d = 1'b0;
        tick_cmd.acc_add = 1'b1;
        smp_d = smp_q + 1'b1;
        if (smp_d >= sts_i.count) begin
          final_tick = 1'b1;
          phase_d    = PH_IDLE;
        end else begin
          phase_d = PH_WAIT;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = accept ? tick_cmd : '0;
    cmd_o.shift_bit = dout_i;
    case (state_q)
      C_AVG_GO:   cmd_o.avg_start = 1'b1;
      C_AVG_WAIT: cmd_o.avg_cap   = sts_i.div_done;
      C_NET_GO:   cmd_o.net_start = 1'b1;
      C_NET_WAIT: cmd_o.net_cap   = sts_i.div_done;
      C_LOAD:     cmd_o.load_res  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_TICK;
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      smp_q       <= '0;
      clk_lvl_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sck_q       <= 1'b0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (beat_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        C_TICK: begin
          if (accept) begin
            phase_q   <= phase_d;
            bit_q     <= bit_d;
            smp_q     <= smp_d;
            clk_lvl_q <= clk_lvl_d;
            if (final_tick) begin
              state_q <= C_AVG_GO;
            end else begin
              sck_q       <= clk_lvl_d;
              busy_q      <= (phase_d != PH_IDLE);
              done_q      <= 1'b0;
            end
          end
        end
        C_AVG_GO:   state_q <= C_AVG_WAIT;
        C_AVG_WAIT: if (sts_i.div_done) state_q <= C_NET_GO;
        C_NET_GO:   state_q <= C_NET_WAIT;
        C_NET_WAIT: if (sts_i.div_done) state_q <= C_LOAD;
        C_LOAD: begin
          if (out_free) begin
            sck_q       <= clk_lvl_q;
            busy_q      <= 1'b0;
            done_q      <= 1'b1;
            state_q     <= C_TICK;
          end
        end
        default: state_q <= C_TICK;
      endcase
    end
  end

  assign in_stall_o  = !((state_q == C_TICK) && out_free);
  assign out_valid_o = out_valid_q;
  assign sck_o       = sck_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;

  `LCAR_ASSERT(a_done_not_busy, out_valid_q && done_q |-> !busy_q, "done beat marked busy")
  `LCAR_ASSERT(a_div_idle_phase, state_q != C_TICK |-> phase_q == PH_IDLE, "divide outside idle phase")
  `LCAR_ASSERT(a_bit_range, bit_q <= lcar_pkg::BIT_IDX_W'(lcar_pkg::DATA_BITS), "bit index overrun")
  `LCAR_ASSERT(a_div_done_wait, sts_i.div_done |-> state_q == C_AVG_WAIT || state_q == C_NET_WAIT, "stray divider done")
  `LCAR_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result beat during reset")

endmodule

// ===== rtl/core/load_cell_adc_reader.sv =====
// Top level of the two-wire bridge ADC reader with averaging and net-weight scaling
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------------
//   tick in  | in_valid_i / in_stall_o | start_req_i, dout_i
//   result   | out_valid_o / out_stall_i | sck_o, busy_res_o, done_res_o,
//            |                         | average_raw_o, net_weight_q8_o
//   config   | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Every tick gives one result beat. The tick that finishes a measurement waits for
// the bit-serial divider, which runs 41 steps for the mean and 41 more for the net
// weight, before its beat is loaded.
// Reset clears the sequencer and loads the register defaults; no clearing pass.
// A stalled result holds its beat; a new tick is taken in the same clock the
// pending beat leaves.
module load_cell_adc_reader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcar_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lcar_pkg::DIVS_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                start_req_i,
  input  logic                                dout_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                sck_o,
  output logic                                busy_res_o,
  output logic                                done_res_o,
  output logic [lcar_pkg::DATA_BITS-1:0]      average_raw_o,
  output logic signed [lcar_pkg::DIVD_W-1:0]  net_weight_q8_o
);

  lcar_pkg::dp_cmd_t cmd;
  lcar_pkg::dp_sts_t sts;

  lcar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_req_i (start_req_i),
    .dout_i      (dout_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sck_o       (sck_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lcar_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .average_raw_o   (average_raw_o),
    .net_weight_q8_o (net_weight_q8_o)
  );

endmodule

// ===== tb/testbench.sv =====
// Testbench for load_cell_adc_reader: tick stream with randomized handshakes, checked beat by beat
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [lcar_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef enum logic [2:0] {
    RD_IDLE, RD_WAIT, RD_RISE, RD_FALL, RD_GAP, RD_XHIGH, RD_XLOW
  } rdr_phase_e;

  typedef struct packed {
    logic start;
    logic d;
  } tick_t;

  typedef struct packed {
    logic                              sck;
    logic                              busy;
    logic                              done;
    logic [lcar_pkg::DATA_BITS-1:0]    avg;
    logic [lcar_pkg::DIVD_W-1:0]       net;
  } reading_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [lcar_pkg::CFG_IDX_W-1:0]      cfg_idx_i;
  logic [lcar_pkg::DIVS_W-1:0]         cfg_data_i;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic                                start_req_i;
  logic                                dout_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic                                sck_o;
  logic                                busy_res_o;
  logic                                done_res_o;
  logic [lcar_pkg::DATA_BITS-1:0]      average_raw_o;
  logic signed [lcar_pkg::DIVD_W-1:0]  net_weight_q8_o;

  load_cell_adc_reader dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_req_i    (start_req_i),
    .dout_i         (dout_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sck_o          (sck_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .average_raw_o  (average_raw_o),
    .net_weight_q8_o(net_weight_q8_o)
  );

  // register copies
  logic [lcar_pkg::CNT_W-1:0]     cnt_cfg   = lcar_pkg::SAMPLE_COUNT_RST;
  logic [lcar_pkg::DATA_BITS-1:0] tare_cfg  = lcar_pkg::TARE_RST;
  logic [lcar_pkg::DIVS_W-1:0]    scale_cfg = lcar_pkg::SCALE_RST;

  // readout state
  rdr_phase_e                     ph        = RD_IDLE;
  logic [lcar_pkg::BIT_IDX_W-1:0] bit_cnt   = '0;
  logic [lcar_pkg::DATA_BITS-1:0] word      = '0;
  logic [lcar_pkg::CNT_W-1:0]     n_done    = '0;
  logic [lcar_pkg::ACC_W-1:0]     acc       = '0;
  logic                           clk_lvl   = 1'b0;
  logic [lcar_pkg::DATA_BITS-1:0] hold_avg  = '0;
  logic [lcar_pkg::DIVD_W-1:0]    hold_net  = '0;

  tick_t    tick_q[$];
  reading_t reading_q[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_on = 1'b0;
  int  hold_cnt = 0;
  bit  tick_taken = 1'b0;
  int  mismatches = 0;
  int  cycle_cnt = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic step_reader(input tick_t t, output reading_t r);
    logic [lcar_pkg::CNT_W-1:0] n_eff;
    logic [lcar_pkg::ACC_W-1:0] mean;
    longint                     diff;
    longint                     divisor;
    longint                     quo;
    logic                       done;
    n_eff = (cnt_cfg == '0) ? lcar_pkg::CNT_W'(1) : cnt_cfg;
    done = 1'b0;
    case (ph)
      RD_IDLE: begin
        clk_lvl = 1'b0;
        if (t.start) begin
          acc = '0;
          n_done = '0;
          ph = RD_WAIT;
        end
      end
      RD_WAIT: begin
        clk_lvl = 1'b0;
        if (!t.d) begin
          bit_cnt = '0;
          word = '0;
          ph = RD_RISE;
        end
      end
      RD_RISE: begin
        clk_lvl = 1'b1;
        ph = RD_FALL;
      end
      RD_FALL: begin
        clk_lvl = 1'b0;
        word = {word[lcar_pkg::DATA_BITS-2:0], t.d};
        bit_cnt = bit_cnt + 1'b1;
        ph = RD_GAP;
      end
      RD_GAP: begin
        if (bit_cnt < lcar_pkg::BIT_IDX_W'(lcar_pkg::DATA_BITS)) begin
          ph = RD_RISE;
        end else begin
          clk_lvl = 1'b1;
          ph = RD_XHIGH;
        end
      end
      RD_XHIGH: begin
        clk_lvl = 1'b0;
        ph = RD_XLOW;
      end
      default: begin
        clk_lvl = 1'b0;
        acc = acc + lcar_pkg::ACC_W'(word ^ 24'h800000);
        n_done = n_done + 1'b1;
        if (n_done >= n_eff) begin
          mean = acc / lcar_pkg::ACC_W'(n_eff);
          hold_avg = mean[lcar_pkg::DATA_BITS-1:0];
          diff = longint'(hold_avg) - longint'(tare_cfg);
          divisor = (scale_cfg == '0) ? 64'sd1 : longint'(scale_cfg);
          quo = (diff * 64'sd65536) / divisor;
          hold_net = quo[lcar_pkg::DIVD_W-1:0];
          done = 1'b1;
          ph = RD_IDLE;
        end else begin
          ph = RD_WAIT;
        end
      end
    endcase
    r.sck  = clk_lvl;
    r.busy = (ph != RD_IDLE);
    r.done = done;
    r.avg  = hold_avg;
    r.net  = hold_net;
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // handshake sampling, prediction and comparison
  always @(posedge clk_i) begin : watch
    reading_t want;
    reading_t got;
    tick_t    t;
    tick_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        t.start = start_req_i;
        t.d = dout_i;
        step_reader(t, want);
        reading_q.push_back(want);
        tick_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.sck  = sck_o;
        got.busy = busy_res_o;
        got.done = done_res_o;
        got.avg  = average_raw_o;
        got.net  = net_weight_q8_o;
        if (reading_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = reading_q.pop_front();
          check_field("sck", want.sck, got.sck);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("average_raw", want.avg, got.avg);
          check_field("net_weight_q8", want.net, got.net);
        end
      end
    end
  end

  // tick driver
  always @(negedge clk_i) begin : drive
    tick_t nxt;
    if (rst_ni && (!in_valid_i || tick_taken)) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = tick_q.pop_front();
        in_valid_i  <= 1'b1;
        start_req_i <= nxt.start;
        dout_i      <= nxt.d;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_on && hold_cnt < HOLD_LEN) begin
      hold_cnt++;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_tick(input logic s, input logic d);
    tick_t t;
    t.start = s;
    t.d = d;
    tick_q.push_back(t);
  endtask

  function automatic logic [lcar_pkg::DATA_BITS-1:0] pick_word();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h800000;
      3: return 24'h7FFFFF;
      default: return lcar_pkg::DATA_BITS'($urandom());
    endcase
  endfunction

  // one conversion: data line wait, 24 clocked bits, trailing pulse
  task automatic queue_conversion(input logic [lcar_pkg::DATA_BITS-1:0] w);
    repeat ($urandom_range(3)) push_tick(1'($urandom_range(1)), 1'b1);
    push_tick(1'($urandom_range(1)), 1'b0);
    for (int b = lcar_pkg::DATA_BITS - 1; b >= 0; b--) begin
      push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      push_tick(1'($urandom_range(1)), w[b]);
      push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic queue_measurement(input logic [lcar_pkg::DATA_BITS-1:0] first_word);
    int n;
    n = (cnt_cfg == '0) ? 1 : int'(cnt_cfg);
    push_tick(1'b1, 1'($urandom_range(1)));
    for (int i = 0; i < n; i++)
      queue_conversion((i == 0) ? first_word : pick_word());
    repeat ($urandom_range(2)) push_tick(1'b0, 1'($urandom_range(1)));
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || reading_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [lcar_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lcar_pkg::DIVS_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      lcar_pkg::CFG_SAMPLE_COUNT: cnt_cfg = val[lcar_pkg::CNT_W-1:0];
      lcar_pkg::CFG_TARE_VALUE:   tare_cfg = val;
      lcar_pkg::CFG_SCALE_Q8:     scale_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    logic [lcar_pkg::CNT_W-1:0] n;
    case ($urandom_range(5))
      0: n = 8'd0;
      4: n = 8'd2;
      5: n = 8'd3;
      default: n = 8'd1;
    endcase
    write_reg(lcar_pkg::CFG_SAMPLE_COUNT, {16'($urandom()), n});
    write_reg(lcar_pkg::CFG_TARE_VALUE, lcar_pkg::DIVS_W'($urandom()));
    if ($urandom_range(1))
      write_reg(lcar_pkg::CFG_SCALE_Q8, lcar_pkg::DIVS_W'($urandom()));
    else
      write_reg(lcar_pkg::CFG_SCALE_Q8, lcar_pkg::DIVS_W'($urandom_range(4096)));
  endtask

  task automatic random_run(input int count);
    for (int m = 0; m < count; m++) begin
      if ($urandom_range(2) == 0) begin
        settle();
        random_config();
      end
      queue_measurement(pick_word());
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    start_req_i = 1'b0;
    dout_i      = 1'b0;
    out_stall_i = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 88;

    // reset register values
    repeat (3) push_tick(1'b0, 1'($urandom_range(1)));
    queue_measurement(24'h123456);
    settle();

    // full-scale positive and negative net weight
    write_reg(lcar_pkg::CFG_SAMPLE_COUNT, 24'hABCD01);
    write_reg(lcar_pkg::CFG_TARE_VALUE, 24'h000000);
    write_reg(lcar_pkg::CFG_SCALE_Q8, 24'h000001);
    queue_measurement(24'h7FFFFF);
    settle();
    write_reg(lcar_pkg::CFG_TARE_VALUE, 24'hFFFFFF);
    queue_measurement(24'h800000);
    settle();

    // zero count and zero scale fall back to one
    write_reg(lcar_pkg::CFG_SAMPLE_COUNT, 24'h5A5A00);
    write_reg(lcar_pkg::CFG_SCALE_Q8, 24'h000000);
    write_reg(lcar_pkg::CFG_TARE_VALUE, 24'h000100);
    queue_measurement(24'h000000);
    queue_measurement(24'hFFFFFF);
    settle();

    // write to an unused index is dropped
    write_reg(CFG_IDX_SPARE, 24'hFFFFFF);
    write_reg(lcar_pkg::CFG_SAMPLE_COUNT, 24'h000002);
    write_reg(lcar_pkg::CFG_TARE_VALUE, 24'h800000);
    write_reg(lcar_pkg::CFG_SCALE_Q8, 24'hFFFFFF);
    queue_measurement(pick_word());
    random_run(1);
    settle();

    send_idle_pct = 88;
    recv_idle_pct = 29;
    random_run(1);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_config();
    hold_on = 1'b1;
    queue_measurement(pick_word());
    random_run(1);
    settle();

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
